### src/tlwd_pkg.sv
// Package for the track loiter dwell detector.
// Holds payload structs, config codes, reset values and the sequencer state type.
// No dependencies.
package tlwd_pkg;

	localparam int TRACK_ID_W = 6;
	localparam int PIX_W      = 12;
	localparam int VEL_W      = 16;
	localparam int TIME_W     = 32;
	localparam int SCORE_W    = 16;
	localparam int SPEED_W    = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// squared config values, kept precomputed
	localparam int RADIUS_SQ_W = 2 * PIX_W;
	localparam int SPEED_SQ_W  = 2 * SPEED_W;

	// reset values of the config registers (squares where stored squared)
	localparam logic [RADIUS_SQ_W-1:0] RADIUS_SQ_RST = RADIUS_SQ_W'(2500);
	localparam logic [SPEED_SQ_W-1:0]  SPEED_SQ_RST  = SPEED_SQ_W'(1024);
	localparam logic [TIME_W-1:0]      THRESHOLD_RST = TIME_W'(10000);
	localparam logic [SCORE_W-1:0]     SCORE_RST     = SCORE_W'(52429);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS    = 2'd0,
		REG_MAX_SPEED = 2'd1,
		REG_THRESHOLD = 2'd2,
		REG_SCORE     = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_OBSERVE = 1'b0,
		OP_PRUNE   = 1'b1
	} op_t;

	typedef struct packed {
		op_t                     operation;
		logic [TRACK_ID_W-1:0]   track_id;
		logic                    track_active;
		logic [PIX_W-1:0]        center_x;
		logic [PIX_W-1:0]        center_y;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [PIX_W-1:0]        box_x;
		logic [PIX_W-1:0]        box_y;
		logic [PIX_W-1:0]        box_w;
		logic [PIX_W-1:0]        box_h;
		logic [TIME_W-1:0]       time_ms;
	} item_t;

	typedef struct packed {
		logic [TRACK_ID_W-1:0] out_track_id;
		logic [SCORE_W-1:0]    out_score;
		logic [PIX_W-1:0]      out_box_x;
		logic [PIX_W-1:0]      out_box_y;
		logic [PIX_W-1:0]      out_box_w;
		logic [PIX_W-1:0]      out_box_h;
		logic [TIME_W-1:0]     dwell_ms;
	} result_t;

	// classified request passed from front to back
	typedef struct packed {
		logic                    is_prune;
		logic [TRACK_ID_W-1:0]   track_id;
		logic [PIX_W-1:0]        center_x;
		logic [PIX_W-1:0]        center_y;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [PIX_W-1:0]        box_x;
		logic [PIX_W-1:0]        box_y;
		logic [PIX_W-1:0]        box_w;
		logic [PIX_W-1:0]        box_h;
		logic [TIME_W-1:0]       time_ms;
	} cmd_t;

	// one dwell table record
	typedef struct packed {
		logic [PIX_W-1:0]  x;
		logic [PIX_W-1:0]  y;
		logic [TIME_W-1:0] start;
	} anchor_t;

	typedef struct packed {
		logic [RADIUS_SQ_W-1:0] radius_sq;
		logic [SPEED_SQ_W-1:0]  speed_sq;
		logic [TIME_W-1:0]      threshold;
		logic [SCORE_W-1:0]     score;
	} cfg_t;

	localparam int CMD_W    = $bits(cmd_t);
	localparam int RESULT_W = $bits(result_t);
	localparam int ANCHOR_W = $bits(anchor_t);

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EXEC = 1'b1
	} back_state_t;

endpackage

### src/tlwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/tlwd_fifo.sv
// Small register queue used between the front and back and at the result side.
// No dependencies.
module tlwd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/tlwd_front.sv
// Front end: accepts input requests and classifies them.
// Depends on tlwd_pkg. Drops requests that have no effect, forwards the rest.
module tlwd_front
	import tlwd_pkg::*;
#(
	parameter int TRACKS = 64
) (
	input  logic  push,
	input  item_t item,
	output logic  full,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_cmd
);

	logic keep;

	// inactive tracks and ids beyond the table leave no trace
	always_comb begin
		keep = (item.operation == OP_PRUNE) ||
		       (item.track_active && (32'(item.track_id) < TRACKS));
	end

	assign full   = q_full;
	assign q_push = push && !q_full && keep;

	// repack into the internal request
	always_comb begin
		q_cmd.is_prune = (item.operation == OP_PRUNE);
		q_cmd.track_id = item.track_id;
		q_cmd.center_x = item.center_x;
		q_cmd.center_y = item.center_y;
		q_cmd.vel_x    = item.vel_x;
		q_cmd.vel_y    = item.vel_y;
		q_cmd.box_x    = item.box_x;
		q_cmd.box_y    = item.box_y;
		q_cmd.box_w    = item.box_w;
		q_cmd.box_h    = item.box_h;
		q_cmd.time_ms  = item.time_ms;
	end

endmodule

### src/tlwd_back.sv
// Back end: dwell table sequencer (read, then check and update).
// Depends on tlwd_pkg and tlwd_ram. Valid and seen marks live in flops.
module tlwd_back
	import tlwd_pkg::*;
#(
	parameter int TRACKS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    cmd_empty,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);

	localparam int IDX_W = $clog2(TRACKS);

	back_state_t             state_q, state_d;
	cmd_t                    cmd_s1;
	logic [2*VEL_W-2:0]      sq_vx_s1, sq_vy_s1;
	logic [TRACKS-1:0]       valid_q, seen_q;
	logic [IDX_W-1:0]        rd_idx, ex_idx;
	anchor_t                 anc, anc_new;
	logic                    start, do_prune, ram_re, ram_we, mark_seen;
	logic signed [2*VEL_W-1:0] vx_sq, vy_sq;
	logic signed [PIX_W:0]   dx, dy;
	logic signed [2*PIX_W+1:0] dx_sq, dy_sq;
	logic [2*PIX_W:0]        dist_sq;
	logic [2*VEL_W-1:0]      speed_sum;
	logic [TIME_W-1:0]       elapsed;
	logic                    reanchor, loiter;

	assign rd_idx = IDX_W'(cmd.track_id);
	assign ex_idx = IDX_W'(cmd_s1.track_id);
	assign start  = !cmd_empty && !res_full;

	// velocity squares, taken while the table read is under way
	assign vx_sq = cmd.vel_x * cmd.vel_x;
	assign vy_sq = cmd.vel_y * cmd.vel_y;

	// distance from the anchor, speed and elapsed time
	always_comb begin
		dx        = $signed({1'b0, cmd_s1.center_x}) - $signed({1'b0, anc.x});
		dy        = $signed({1'b0, cmd_s1.center_y}) - $signed({1'b0, anc.y});
		dx_sq     = dx * dx;
		dy_sq     = dy * dy;
		dist_sq   = {1'b0, dx_sq[2*PIX_W-1:0]} + {1'b0, dy_sq[2*PIX_W-1:0]};
		speed_sum = {1'b0, sq_vx_s1} + {1'b0, sq_vy_s1};
		elapsed   = cmd_s1.time_ms - anc.start;
		reanchor  = !valid_q[ex_idx] ||
		            (dist_sq > {1'b0, cfg.radius_sq});
		loiter    = (speed_sum <= {{(2*VEL_W-SPEED_SQ_W){1'b0}}, cfg.speed_sq}) &&
		            (elapsed >= cfg.threshold);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (start && !cmd.is_prune) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_pop   = 1'b0;
		do_prune  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		mark_seen = 1'b0;
		res_push  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (start) begin
					cmd_pop  = 1'b1;
					do_prune = cmd.is_prune;
					ram_re   = !cmd.is_prune;
				end
			end
			BK_EXEC: begin
				mark_seen = 1'b1;
				ram_we    = reanchor;
				res_push  = !reanchor && loiter;
			end
			default: begin
			end
		endcase
	end

	assign anc_new.x     = cmd_s1.center_x;
	assign anc_new.y     = cmd_s1.center_y;
	assign anc_new.start = cmd_s1.time_ms;

	// result fields
	always_comb begin
		res.out_track_id = cmd_s1.track_id;
		res.out_score    = cfg.score;
		res.out_box_x    = cmd_s1.box_x;
		res.out_box_y    = cmd_s1.box_y;
		res.out_box_w    = cmd_s1.box_w;
		res.out_box_h    = cmd_s1.box_h;
		res.dwell_ms     = elapsed;
	end

	// dwell table: anchor and start time
	tlwd_ram #(
		.WIDTH(ANCHOR_W),
		.DEPTH(TRACKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ex_idx),
		.wdata(anc_new),
		.re   (ram_re),
		.raddr(rd_idx),
		.rdata(anc)
	);

	// request and velocity squares held for the execute cycle
	always_ff @(posedge clk) begin
		if (ram_re) begin
			cmd_s1   <= cmd;
			sq_vx_s1 <= vx_sq[2*VEL_W-2:0];
			sq_vy_s1 <= vy_sq[2*VEL_W-2:0];
		end
	end

	// state, valid and seen marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= '0;
			seen_q  <= '0;
		end else begin
			state_q <= state_d;
			if (do_prune) begin
				valid_q <= valid_q & seen_q;
				seen_q  <= '0;
			end
			if (mark_seen) begin
				seen_q[ex_idx] <= 1'b1;
			end
			if (ram_we) begin
				valid_q[ex_idx] <= 1'b1;
			end
		end
	end

endmodule

### src/track_loiter_dwell_detector_unit.sv
// Top level of the track loiter dwell detector.
// Depends on tlwd_pkg, tlwd_front, tlwd_back, tlwd_fifo, tlwd_ram.
//
//  Channel   Handshake          Payload
//  --------  -----------------  -------------------------------
//  input     push / full        item   (item_t)
//  result    empty / pop        result (result_t)
//  config    cfg_we             cfg_index, cfg_data
//
// An observe request passes through two back-end steps (table read, then check and
// write back); a prune is done in one. Requests that change nothing are dropped
// in the front and never reach the back end. Reset clears all valid and seen
// marks at once; no clearing pass. A two-entry queue parts front and back,
// and a two-entry result queue lets the block keep working while pop is low.
module track_loiter_dwell_detector_unit
	import tlwd_pkg::*;
#(
	parameter int TRACKS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  item_t                 item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                  cfg_q;
	logic                  q_push, q_full, q_empty, q_pop;
	cmd_t                  q_cmd, q_head;
	logic [CMD_W-1:0]      q_rdata;
	logic                  res_push, res_full;
	result_t               res;
	logic [RESULT_W-1:0]   res_rdata;
	logic [PIX_W-1:0]      radius_in;
	logic [SPEED_W-1:0]    speed_in;

	assign radius_in = cfg_data[PIX_W-1:0];
	assign speed_in  = cfg_data[SPEED_W-1:0];

	// config registers; radius and speed are kept squared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius_sq <= RADIUS_SQ_RST;
			cfg_q.speed_sq  <= SPEED_SQ_RST;
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.score     <= SCORE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS: begin
					cfg_q.radius_sq <= RADIUS_SQ_W'(radius_in) * RADIUS_SQ_W'(radius_in);
				end
				REG_MAX_SPEED: begin
					cfg_q.speed_sq <= SPEED_SQ_W'(speed_in) * SPEED_SQ_W'(speed_in);
				end
				REG_THRESHOLD: begin
					cfg_q.threshold <= cfg_data[TIME_W-1:0];
				end
				REG_SCORE: begin
					cfg_q.score <= cfg_data[SCORE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify
	tlwd_front #(
		.TRACKS(TRACKS)
	) u_front (
		.push  (push),
		.item  (item),
		.full  (full),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd (q_cmd)
	);

	// request queue between front and back
	tlwd_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_cmd),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign q_head = cmd_t'(q_rdata);

	// back: dwell table update and anomaly check
	tlwd_back #(
		.TRACKS(TRACKS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_empty(q_empty),
		.cmd      (q_head),
		.cmd_pop  (q_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// result queue
	tlwd_fifo #(
		.WIDTH(RESULT_W),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign result = result_t'(res_rdata);

endmodule

### tb/tb_track_loiter_dwell_detector_unit.sv
// Testbench for track_loiter_dwell_detector_unit: directed table, a back-pressure run, then random phases.
// Every accepted request is run through a local dwell-table predictor; results are checked in order.
// Depends on tlwd_pkg and the track_loiter_dwell_detector_unit RTL.
`timescale 1ns / 100ps

module tb_track_loiter_dwell_detector_unit;
	import tlwd_pkg::*;

	localparam int TRACKS       = 64;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;
	localparam int RAND_PHASES  = 9;
	localparam int PHASE_ITEMS  = 180;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_HALF,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	// one directed row: typed expectation used when chk is set
	typedef struct packed {
		logic    chk;
		logic    hit;
		result_t res;
		item_t   it;
	} row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	item_t                 item      = '0;
	logic                  full;
	logic                  empty;
	logic                  pop       = 1'b0;
	result_t               result;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// typed expectation travels with the request it belongs to
	logic    typed_on  = 1'b0;
	logic    typed_hit = 1'b0;
	result_t typed_res = '0;

	// predictor copy of the dwell table and config
	logic              ent_valid [TRACKS];
	logic              ent_seen  [TRACKS];
	logic [PIX_W-1:0]  anc_x     [TRACKS];
	logic [PIX_W-1:0]  anc_y     [TRACKS];
	logic [TIME_W-1:0] anc_t     [TRACKS];
	logic [11:0]       cfg_radius = 12'd50;
	logic [14:0]       cfg_speed  = 15'd32;
	logic [31:0]       cfg_thr    = 32'd10000;
	logic [15:0]       cfg_score  = 16'd52429;

	result_t anom_q[$];
	int      errors = 0;

	// stimulus-side scene state
	int          tgt_x [TRACKS];
	int          tgt_y [TRACKS];
	bit          tgt_set [TRACKS];
	logic [31:0] now_ms = '0;
	int          pool   = 8;

	// receiver state
	int       hold_seq  = 0;
	int       hold_done = 0;
	int       hold_left = 0;
	int       mode_left = 0;
	rx_mode_t rx_mode   = RX_FREE;

	row_t rows[$];

	track_loiter_dwell_detector_unit #(
		.TRACKS(TRACKS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// dwell table update for one request; hit set when an anomaly is raised
	task automatic step_dwell(input item_t it, output logic hit, output result_t r);
		int     id;
		longint dx, dy, vx, vy, dist2, speed2, rad, lim;
		logic [TIME_W-1:0] elapsed;
		hit = 1'b0;
		r   = '0;
		if (it.operation == OP_PRUNE) begin
			for (int i = 0; i < TRACKS; i++) begin
				ent_valid[i] = ent_valid[i] & ent_seen[i];
				ent_seen[i]  = 1'b0;
			end
		end else if (it.track_active && int'(it.track_id) < TRACKS) begin
			id = int'(it.track_id);
			ent_seen[id] = 1'b1;
			dx    = longint'(it.center_x) - longint'(anc_x[id]);
			dy    = longint'(it.center_y) - longint'(anc_y[id]);
			dist2 = dx * dx + dy * dy;
			rad   = longint'(cfg_radius);
			if (!ent_valid[id] || dist2 > rad * rad) begin
				anc_x[id]     = it.center_x;
				anc_y[id]     = it.center_y;
				anc_t[id]     = it.time_ms;
				ent_valid[id] = 1'b1;
			end else begin
				vx      = longint'($signed(it.vel_x));
				vy      = longint'($signed(it.vel_y));
				speed2  = vx * vx + vy * vy;
				lim     = longint'(cfg_speed);
				elapsed = it.time_ms - anc_t[id];
				if (speed2 <= lim * lim && elapsed >= cfg_thr) begin
					hit            = 1'b1;
					r.out_track_id = it.track_id;
					r.out_score    = cfg_score;
					r.out_box_x    = it.box_x;
					r.out_box_y    = it.box_y;
					r.out_box_w    = it.box_w;
					r.out_box_h    = it.box_h;
					r.dwell_ms     = elapsed;
				end
			end
		end
	endtask

	task automatic flag_bad(input string what, input result_t e, input result_t a);
		errors++;
		if (errors <= 10) begin
			$display("mismatch %0d (%s) at %0t: exp id=%0d score=%0d box=%0d,%0d,%0d,%0d dwell=%0d",
				errors, what, $realtime, e.out_track_id, e.out_score, e.out_box_x, e.out_box_y,
				e.out_box_w, e.out_box_h, e.dwell_ms);
			$display("    got id=%0d score=%0d box=%0d,%0d,%0d,%0d dwell=%0d",
				a.out_track_id, a.out_score, a.out_box_x, a.out_box_y, a.out_box_w, a.out_box_h,
				a.dwell_ms);
		end
	endtask

	// scoreboard: predict on accepted requests, check accepted results
	always @(posedge clk) begin : score_blk
		logic    hit;
		result_t pr, e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (anom_q.size() == 0) begin
					flag_bad("unexpected result", '0, result);
				end else begin
					e = anom_q.pop_front();
					if (result.out_track_id !== e.out_track_id || result.out_score !== e.out_score ||
					    result.out_box_x !== e.out_box_x || result.out_box_y !== e.out_box_y ||
					    result.out_box_w !== e.out_box_w || result.out_box_h !== e.out_box_h ||
					    result.dwell_ms !== e.dwell_ms) begin
						flag_bad("field mismatch", e, result);
					end
				end
			end
			if (push && !full) begin
				step_dwell(item, hit, pr);
				if (typed_on) begin
					hit = typed_hit;
					pr  = typed_res;
				end
				if (hit) begin
					anom_q = {anom_q, pr};
				end
			end
		end
	end

	// receiver: random stall pattern, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop       <= 1'b0;
		end else if (hold_seq != hold_done) begin
			hold_done <= hold_seq;
			hold_left <= HOLD_CYCLES;
			pop       <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(32, 128);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_FREE:   pop <= 1'b1;
				RX_HALF:   pop <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: pop <= ($urandom_range(0, 9) == 0);
				default:   pop <= ~pop;
			endcase
		end
	end

	function automatic item_t mk_item(input op_t op, input int id, input logic act, input int cx,
		input int cy, input int vx, input int vy, input int bx, input int by, input int bw,
		input int bh, input logic [31:0] t);
		item_t it;
		it.operation    = op;
		it.track_id     = TRACK_ID_W'(id);
		it.track_active = act;
		it.center_x     = PIX_W'(cx);
		it.center_y     = PIX_W'(cy);
		it.vel_x        = VEL_W'(vx);
		it.vel_y        = VEL_W'(vy);
		it.box_x        = PIX_W'(bx);
		it.box_y        = PIX_W'(by);
		it.box_w        = PIX_W'(bw);
		it.box_h        = PIX_W'(bh);
		it.time_ms      = t;
		return it;
	endfunction

	function automatic result_t mk_res(input int id, input int sc, input int bx, input int by,
		input int bw, input int bh, input logic [31:0] d);
		result_t r;
		r.out_track_id = TRACK_ID_W'(id);
		r.out_score    = SCORE_W'(sc);
		r.out_box_x    = PIX_W'(bx);
		r.out_box_y    = PIX_W'(by);
		r.out_box_w    = PIX_W'(bw);
		r.out_box_h    = PIX_W'(bh);
		r.dwell_ms     = d;
		return r;
	endfunction

	task automatic add_row(input item_t it, input logic chk, input logic hit, input result_t res);
		row_t rw;
		rw.chk = chk;
		rw.hit = hit;
		rw.res = res;
		rw.it  = it;
		rows = {rows, rw};
	endtask

	// random request: mostly loitering sequences around per-track targets
	function automatic item_t gen_item();
		item_t        it;
		logic [159:0] noise;
		int           sel, id, jit, vj, ms, cx, cy, vx, vy;
		int unsigned  up;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it    = noise[$bits(item_t)-1:0];
		sel   = $urandom_range(0, 99);
		if (sel < 6) begin
			it.operation = OP_PRUNE;
		end else if (sel < 10) begin
			it.operation = OP_OBSERVE;
		end else begin
			id = $urandom_range(0, pool - 1);
			if (!tgt_set[id] || $urandom_range(0, 99) < 3) begin
				tgt_x[id]   = $urandom_range(0, 4095);
				tgt_y[id]   = $urandom_range(0, 4095);
				tgt_set[id] = 1'b1;
			end
			// small jitter stays inside the radius, wide jitter can cross it
			jit = (int'(cfg_radius) * 35) / 100;
			if ($urandom_range(0, 99) < 15) begin
				jit = int'(cfg_radius) + int'(cfg_radius) / 4 + 2;
			end
			cx = tgt_x[id] + int'($urandom_range(0, 2 * jit)) - jit;
			cy = tgt_y[id] + int'($urandom_range(0, 2 * jit)) - jit;
			cx = (cx < 0) ? 0 : ((cx > 4095) ? 4095 : cx);
			cy = (cy < 0) ? 0 : ((cy > 4095) ? 4095 : cy);
			ms  = int'(cfg_speed);
			vj  = (ms * 7) / 10;
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				vx = ($urandom_range(0, 1) == 1) ? ms : -ms;
				vy = 0;
			end else if (sel < 85) begin
				vx = int'($urandom_range(0, 2 * vj)) - vj;
				vy = int'($urandom_range(0, 2 * vj)) - vj;
			end else begin
				vx = int'($urandom_range(0, 65535)) - 32768;
				vy = int'($urandom_range(0, 65535)) - 32768;
			end
			up = (cfg_thr == 0) ? 50 : cfg_thr / 6 + 1;
			if ($urandom_range(0, 99) < 2) begin
				now_ms = $urandom;
			end else begin
				now_ms = now_ms + $urandom_range(0, up);
			end
			it.operation    = OP_OBSERVE;
			it.track_id     = TRACK_ID_W'(id);
			it.track_active = ($urandom_range(0, 99) < 95);
			it.center_x     = PIX_W'(cx);
			it.center_y     = PIX_W'(cy);
			it.vel_x        = VEL_W'(vx);
			it.vel_y        = VEL_W'(vy);
			it.time_ms      = now_ms;
		end
		return it;
	endfunction

	// offer one request and hold it until it is taken
	task automatic offer(input item_t it, input logic chk, input logic hit, input result_t res);
		push      <= 1'b1;
		item      <= it;
		typed_on  <= chk;
		typed_hit <= hit;
		typed_res <= res;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic idle_for(input int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stop sending and wait until every expected anomaly has come out
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (anom_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_reg_t idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_RADIUS:    cfg_radius = data[11:0];
			REG_MAX_SPEED: cfg_speed  = data[14:0];
			REG_THRESHOLD: cfg_thr    = data;
			default:       cfg_score  = data[15:0];
		endcase
	endtask

	// unused high bits of the write data carry random junk
	task automatic set_config(input int r, input int ms, input logic [31:0] thr, input int sc);
		logic [31:0] d;
		d = $urandom; d[11:0] = 12'(r);  write_cfg(REG_RADIUS, d);
		d = $urandom; d[14:0] = 15'(ms); write_cfg(REG_MAX_SPEED, d);
		write_cfg(REG_THRESHOLD, thr);
		d = $urandom; d[15:0] = 16'(sc); write_cfg(REG_SCORE, d);
	endtask

	// run limit
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : main
		int      n, burst;
		result_t none;
		none = '0;
		for (int i = 0; i < TRACKS; i++) begin
			ent_valid[i] = 1'b0;
			ent_seen[i]  = 1'b0;
			anc_x[i]     = '0;
			anc_y[i]     = '0;
			anc_t[i]     = '0;
			tgt_set[i]   = 1'b0;
		end

		// directed table, run on reset config
		add_row(mk_item(OP_OBSERVE, 5, 1, 100, 100, 0, 0, 10, 20, 30, 40, 0), 1, 0, none);
		// distance, speed and elapsed all exactly at their limits
		add_row(mk_item(OP_OBSERVE, 5, 1, 130, 140, 32, 0, 1, 2, 3, 4, 10000), 1, 1,
			mk_res(5, 52429, 1, 2, 3, 4, 10000));
		add_row(mk_item(OP_OBSERVE, 5, 1, 130, 140, 32, 1, 1, 2, 3, 4, 20000), 1, 0, none);
		add_row(mk_item(OP_OBSERVE, 5, 1, 100, 100, 0, -32, 7, 8, 9, 10, 19999), 0, 0, none);
		// just outside the radius: re-anchor
		add_row(mk_item(OP_OBSERVE, 5, 1, 131, 140, 0, 0, 1, 1, 1, 1, 30000), 1, 0, none);
		add_row(mk_item(OP_OBSERVE, 5, 1, 131, 140, 0, 0, 1, 1, 1, 1, 39999), 1, 0, none);
		// inactive track is a no-op
		add_row(mk_item(OP_OBSERVE, 5, 0, 131, 140, 0, 0, 1, 1, 1, 1, 60000), 1, 0, none);
		// first prune keeps the seen track, second drops it
		add_row(mk_item(OP_PRUNE, 5, 1, 131, 140, 0, 0, 9, 9, 9, 9, 0), 1, 0, none);
		add_row(mk_item(OP_PRUNE, 0, 0, 4095, 0, -1, 7, 4095, 0, 4095, 0, 32'hFFFF_FFFF), 1, 0,
			none);
		add_row(mk_item(OP_OBSERVE, 5, 1, 131, 140, 0, 0, 1, 1, 1, 1, 70000), 1, 0, none);
		// elapsed time across the 32-bit wrap
		add_row(mk_item(OP_OBSERVE, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_F000), 1, 0, none);
		add_row(mk_item(OP_OBSERVE, 7, 1, 0, 0, -32, 0, 5, 6, 7, 8, 32'h0000_1710), 1, 1,
			mk_res(7, 52429, 5, 6, 7, 8, 10000));
		// field extremes
		add_row(mk_item(OP_OBSERVE, 63, 1, 4095, 4095, 0, 0, 0, 0, 0, 0, 0), 1, 0, none);
		add_row(mk_item(OP_OBSERVE, 63, 1, 4095, 4095, 0, 0, 4095, 4095, 4095, 4095,
			32'hFFFF_FFFF), 1, 1, mk_res(63, 52429, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF));
		add_row(mk_item(OP_OBSERVE, 63, 1, 0, 0, 0, 0, 0, 0, 0, 0, 5), 1, 0, none);
		add_row(mk_item(OP_OBSERVE, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 100), 1, 0, none);
		add_row(mk_item(OP_OBSERVE, 0, 1, 0, 0, -32768, -32768, 1, 1, 1, 1, 20000), 1, 0, none);
		add_row(mk_item(OP_OBSERVE, 0, 1, 35, 35, -22, -23, 3, 3, 3, 3, 20100), 0, 0, none);
		add_row(mk_item(OP_OBSERVE, 0, 1, 0, 0, 32767, 0, 3, 3, 3, 3, 10099), 0, 0, none);
		add_row(mk_item(OP_OBSERVE, 0, 1, 0, 0, 0, 0, 3, 3, 3, 3, 10099), 1, 0, none);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			offer(rows[i].it, rows[i].chk, rows[i].hit, rows[i].res);
			if ($urandom_range(0, 2) == 0) begin
				idle_for($urandom_range(1, 4));
			end
		end
		drain();

		// back-pressure: every request after the first raises an anomaly while the receiver holds off
		set_config(4095, 32767, 0, 777);
		hold_seq <= hold_seq + 1;
		for (int k = 0; k < 40; k++) begin
			offer(mk_item(OP_OBSERVE, 9, 1, 2000, 2000, 0, 0, k, k, k, k, 32'(k * 40)), 0, 0,
				none);
		end
		drain();

		// random phases, each under its own config
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: set_config(50, 32, 10000, 52429);
				1: set_config(0, 0, 0, 0);
				2: set_config(4095, 32767, 32'hFFFF_FFFF, 65535);
				3: set_config(4095, 32767, 0, 65535);
				default: set_config(
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 300),
					$urandom_range(0, 50000), $urandom_range(0, 65535));
			endcase
			pool = (ph % 3 == 0) ? 64 : ((ph % 3 == 1) ? 4 : 12);
			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
				for (int b = 0; b < burst && n < PHASE_ITEMS; b++) begin
					offer(gen_item(), 0, 0, none);
					n++;
				end
				if ($urandom_range(0, 9) < 7) begin
					idle_for($urandom_range(1, 6));
				end
			end
			drain();
		end

		if (anom_q.size() != 0) begin
			$display("%0d expected anomalies never arrived", anom_q.size());
		end
		if (errors == 0 && anom_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
